### hdl/bmh_pkg.sv
// shared types and constants for the binary min-heap priority queue
// no dependencies; every other file of the block but bmh_ram uses this package

package bmh_pkg;

    localparam int DEFAULT_CAPACITY = 1024;
    localparam int KEY_W            = 32;
    localparam int COUNT_W          = 11;
    localparam int STATUS_W         = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE_LOAD,
        S_UP_STEP,
        S_UP_CMP,
        S_DN_STEP,
        S_DN_CMP,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INSERT,
        OP_REJECT_FULL,
        OP_REMOVE,
        OP_REJECT_EMPTY,
        OP_LOAD_LAST,
        OP_PLACE,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_DN_READ,
        OP_DN_MOVE,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic cnt_zero;
        logic at_root;
        logic parent_gt;
        logic no_child;
        logic down_swap;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/binary_min_heap.sv
// top level of the binary min-heap priority queue
// depends on bmh_pkg, bmh_ctrl, bmh_dpath (which holds the bmh_ram store)
//
// One word in, one word out. An insert word places its key at the end of the
// heap and walks it up; a remove word returns the root and walks the last key
// down from the root. Each word returns the removed key, the new minimum, the
// key count and a status (remove on empty and insert on full leave the heap
// as it was). One word is worked on at a time. The walk goes through the key
// memory one level per step: a registered read of the parent (or of both
// children over the memory's two read ports), then a compare and one write.
// A walk moves at most log2(CAPACITY) levels. A new word is taken while the
// previous result still waits in the output register.

module binary_min_heap #(
    parameter int CAPACITY = bmh_pkg::DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  bmh_pkg::key_t                 key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bmh_pkg::key_t                 removed_key,
    output bmh_pkg::key_t                 min_key,
    output logic [bmh_pkg::COUNT_W-1:0]   entry_count,
    output logic [bmh_pkg::STATUS_W-1:0]  status
);

    import bmh_pkg::*;

    op_t        op;
    dp_status_t st;

    bmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .st       (st),
        .op       (op)
    );

    bmh_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .st          (st),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .removed_key (removed_key),
        .min_key     (min_key),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule

### hdl/bmh_ram.sv
// generic single-write, dual-read memory with registered read data
// no dependencies

module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hdl/bmh_ctrl.sv
// sequencer for insert (sift up) and remove (sift down) operations
// depends on bmh_pkg; drives datapath commands, reads datapath status

module bmh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  bmh_pkg::dp_status_t st,
    output bmh_pkg::op_t        op
);

    import bmh_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        state_next = st.full ? S_DONE : S_UP_STEP;
                    end
                    else
                    begin
                        state_next = st.empty ? S_DONE : S_REMOVE_LOAD;
                    end
                end
            end
            S_REMOVE_LOAD: state_next = st.cnt_zero ? S_DONE : S_DN_STEP;
            S_UP_STEP:     state_next = st.at_root ? S_DONE : S_UP_CMP;
            S_UP_CMP:      state_next = st.parent_gt ? S_UP_STEP : S_DONE;
            S_DN_STEP:     state_next = st.no_child ? S_DONE : S_DN_CMP;
            S_DN_CMP:      state_next = st.down_swap ? S_DN_STEP : S_DONE;
            S_DONE:        state_next = st.out_free ? S_IDLE : S_DONE;
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op       = OP_NOP;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        op = st.full ? OP_REJECT_FULL : OP_INSERT;
                    end
                    else
                    begin
                        op = st.empty ? OP_REJECT_EMPTY : OP_REMOVE;
                    end
                end
            end
            S_REMOVE_LOAD: op = OP_LOAD_LAST;
            S_UP_STEP:     op = st.at_root ? OP_PLACE : OP_UP_READ;
            S_UP_CMP:      op = st.parent_gt ? OP_UP_MOVE : OP_PLACE;
            S_DN_STEP:     op = st.no_child ? OP_PLACE : OP_DN_READ;
            S_DN_CMP:      op = st.down_swap ? OP_DN_MOVE : OP_PLACE;
            S_DONE:        op = st.out_free ? OP_PUBLISH : OP_NOP;
            default:       op = OP_NOP;
        endcase
    end

endmodule

### hdl/bmh_dpath.sv
// heap datapath: key store, fill count, hole position, compares, result register
// depends on bmh_pkg and bmh_ram

module bmh_dpath #(
    parameter int CAPACITY = bmh_pkg::DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bmh_pkg::op_t                  op,
    output bmh_pkg::dp_status_t           st,
    input  bmh_pkg::key_t                 key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bmh_pkg::key_t                 removed_key,
    output bmh_pkg::key_t                 min_key,
    output logic [bmh_pkg::COUNT_W-1:0]   entry_count,
    output logic [bmh_pkg::STATUS_W-1:0]  status
);

    import bmh_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = CAPACITY + 1;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       pos_reg, pos_next;
    key_t                cur_reg, cur_next;
    key_t                root_reg, root_next;
    key_t                removed_reg, removed_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;

    logic                out_valid_reg, out_valid_next;
    key_t                out_removed_reg, out_removed_next;
    key_t                out_min_reg, out_min_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [STATUS_W-1:0] out_stat_reg, out_stat_next;

    logic          we;
    logic [CW-1:0] waddr;
    key_t          wdata;
    logic [CW-1:0] raddr_a, raddr_b;
    logic [KEY_W-1:0] rdata_a, rdata_b;
    key_t          rd_a, rd_b;

    logic [CW:0]   left_idx, right_idx, count_ext;
    logic          has_right, pick_right;
    key_t          pick_val;
    logic [CW+COUNT_W-1:0] count_wide;

    bmh_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign rd_a = $signed(rdata_a);
    assign rd_b = $signed(rdata_b);

    assign left_idx   = {pos_reg, 1'b0};
    assign right_idx  = {pos_reg, 1'b1};
    assign count_ext  = {1'b0, count_reg};
    assign has_right  = (right_idx <= count_ext);
    assign pick_right = has_right && !(rd_b > rd_a);
    assign pick_val   = pick_right ? rd_b : rd_a;
    assign count_wide = {{COUNT_W{1'b0}}, count_reg};

    always_comb
    begin
        st.full      = (count_reg == CW'(CAPACITY));
        st.empty     = (count_reg == '0);
        st.cnt_zero  = (count_reg == '0);
        st.at_root   = (pos_reg == CW'(1));
        st.parent_gt = (rd_a > cur_reg);
        st.no_child  = (left_idx > count_ext);
        st.down_swap = (cur_reg > pick_val);
        st.out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        removed_next = removed_reg;
        stat_next    = stat_reg;
        we           = 1'b0;
        waddr        = pos_reg;
        wdata        = cur_reg;
        raddr_a      = '0;
        raddr_b      = '0;

        out_removed_next = out_removed_reg;
        out_min_next     = out_min_reg;
        out_count_next   = out_count_reg;
        out_stat_next    = out_stat_reg;
        out_valid_next   = out_valid_reg && out_stall;

        case (op)
            OP_INSERT:
            begin
                count_next   = count_reg + CW'(1);
                pos_next     = count_reg + CW'(1);
                cur_next     = key;
                removed_next = '0;
                stat_next    = STATUS_OK;
            end
            OP_REJECT_FULL:
            begin
                removed_next = '0;
                stat_next    = STATUS_FULL;
            end
            OP_REJECT_EMPTY:
            begin
                removed_next = '0;
                stat_next    = STATUS_EMPTY;
            end
            OP_REMOVE:
            begin
                raddr_a      = count_reg;
                count_next   = count_reg - CW'(1);
                removed_next = root_reg;
                stat_next    = STATUS_OK;
            end
            OP_LOAD_LAST:
            begin
                cur_next = rd_a;
                pos_next = CW'(1);
            end
            OP_PLACE:
            begin
                we = 1'b1;
            end
            OP_UP_READ:
            begin
                raddr_a = pos_reg >> 1;
            end
            OP_UP_MOVE:
            begin
                we       = 1'b1;
                wdata    = rd_a;
                pos_next = pos_reg >> 1;
            end
            OP_DN_READ:
            begin
                raddr_a = left_idx[CW-1:0];
                raddr_b = right_idx[CW-1:0];
            end
            OP_DN_MOVE:
            begin
                we       = 1'b1;
                wdata    = pick_val;
                pos_next = pick_right ? right_idx[CW-1:0] : left_idx[CW-1:0];
            end
            OP_PUBLISH:
            begin
                out_valid_next   = 1'b1;
                out_removed_next = removed_reg;
                out_min_next     = (count_reg != '0) ? root_reg : '0;
                out_count_next   = count_wide[COUNT_W-1:0];
                out_stat_next    = stat_reg;
            end
            default:
            begin
            end
        endcase
    end

    // root copy kept alongside the store
    always_comb
    begin
        root_next = root_reg;
        if (we && (waddr == CW'(1)))
        begin
            root_next = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        cur_reg         <= cur_next;
        root_reg        <= root_next;
        removed_reg     <= removed_next;
        stat_reg        <= stat_next;
        out_removed_reg <= out_removed_next;
        out_min_reg     <= out_min_next;
        out_count_reg   <= out_count_next;
        out_stat_reg    <= out_stat_next;
    end

    assign out_valid   = out_valid_reg;
    assign removed_key = out_removed_reg;
    assign min_key     = out_min_reg;
    assign entry_count = out_count_reg;
    assign status      = out_stat_reg;

endmodule

### sim/tb_top.sv
// self-checking testbench for binary_min_heap: directed table, then random phases
// depends on bmh_pkg and the binary_min_heap rtl; holds its own heap predictor

module tb_top;
    import bmh_pkg::*;

    localparam int   CAP            = DEFAULT_CAPACITY;
    localparam int   LONG_HOLD      = 400;
    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   DRAIN_CYCLES   = 40;
    localparam key_t KEY_MIN        = 32'sh8000_0000;
    localparam key_t KEY_MAX        = 32'sh7fff_ffff;
    localparam int   NUM_ROWS       = 23;

    typedef struct packed {
        key_t                rm;
        key_t                mn;
        logic [COUNT_W-1:0]  cnt;
        logic [STATUS_W-1:0] st;
    } heap_result_t;

    typedef struct packed {
        logic         kind;
        key_t         key;
        logic         typed;
        heap_result_t res;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                kind = KIND_INSERT;
    key_t                key = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    key_t                removed_key;
    key_t                min_key;
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;

    key_t         heap_keys [1:CAP];
    int unsigned  heap_fill = 0;
    heap_result_t pending_results [$];
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           hold_requests = 0;
    int           holds_done = 0;
    bit           calm = 1'b0;

    // typed rows: empty, extremes, sign patterns; the rest go through the predictor
    stim_row_t dir_rows [NUM_ROWS] = '{
        '{KIND_REMOVE, 32'sd0,          1'b1, '{32'sd0, 32'sd0, 11'd0, STATUS_EMPTY}},
        '{KIND_INSERT, KEY_MAX,         1'b1, '{32'sd0, KEY_MAX, 11'd1, STATUS_OK}},
        '{KIND_INSERT, KEY_MIN,         1'b1, '{32'sd0, KEY_MIN, 11'd2, STATUS_OK}},
        '{KIND_INSERT, 32'sd0,          1'b1, '{32'sd0, KEY_MIN, 11'd3, STATUS_OK}},
        '{KIND_INSERT, -32'sd1,         1'b1, '{32'sd0, KEY_MIN, 11'd4, STATUS_OK}},
        '{KIND_REMOVE, 32'sh1234_5678,  1'b1, '{KEY_MIN, -32'sd1, 11'd3, STATUS_OK}},
        '{KIND_REMOVE, -32'sd1,         1'b1, '{-32'sd1, 32'sd0, 11'd2, STATUS_OK}},
        '{KIND_INSERT, 32'sd5,          1'b0, '0},
        '{KIND_INSERT, 32'sd5,          1'b0, '0},
        '{KIND_INSERT, 32'sd5,          1'b0, '0},
        '{KIND_INSERT, 32'sd3,          1'b0, '0},
        '{KIND_REMOVE, 32'sd0,          1'b0, '0},
        '{KIND_REMOVE, KEY_MAX,         1'b0, '0},
        '{KIND_REMOVE, 32'sd0,          1'b0, '0},
        '{KIND_REMOVE, KEY_MIN,         1'b0, '0},
        '{KIND_REMOVE, 32'sd0,          1'b0, '0},
        '{KIND_REMOVE, 32'sd0,          1'b0, '0},
        '{KIND_REMOVE, 32'sd7,          1'b1, '{32'sd0, 32'sd0, 11'd0, STATUS_EMPTY}},
        '{KIND_INSERT, 32'sh5555_5555,  1'b1, '{32'sd0, 32'sh5555_5555, 11'd1, STATUS_OK}},
        '{KIND_INSERT, 32'shaaaa_aaaa,  1'b1,
          '{32'sd0, 32'shaaaa_aaaa, 11'd2, STATUS_OK}},
        '{KIND_REMOVE, 32'sd0,          1'b1,
          '{32'shaaaa_aaaa, 32'sh5555_5555, 11'd1, STATUS_OK}},
        '{KIND_REMOVE, 32'sd0,          1'b1, '{32'sh5555_5555, 32'sd0, 11'd0, STATUS_OK}},
        '{KIND_REMOVE, 32'sd0,          1'b1, '{32'sd0, 32'sd0, 11'd0, STATUS_EMPTY}}
    };

    binary_min_heap #(
        .CAPACITY(CAP)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .removed_key(removed_key),
        .min_key    (min_key),
        .entry_count(entry_count),
        .status     (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void swap_keys(input int unsigned a, input int unsigned b);
        key_t t;
        t            = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic heap_result_t apply_word(input logic k, input key_t v);
        heap_result_t r;
        int unsigned  pos;
        int unsigned  lc;
        int unsigned  rc;
        int unsigned  pick;
        bit           done;
        r = '0;
        r.st = STATUS_OK;
        if (k == KIND_INSERT)
        begin
            if (heap_fill >= CAP)
                r.st = STATUS_FULL;
            else
            begin
                heap_fill++;
                heap_keys[heap_fill] = v;
                pos = heap_fill;
                while (pos > 1 && heap_keys[pos / 2] > heap_keys[pos])
                begin
                    swap_keys(pos, pos / 2);
                    pos = pos / 2;
                end
            end
        end
        else if (heap_fill == 0)
            r.st = STATUS_EMPTY;
        else
        begin
            r.rm = heap_keys[1];
            heap_keys[1] = heap_keys[heap_fill];
            heap_fill--;
            pos  = 1;
            done = 1'b0;
            while (!done)
            begin
                lc = 2 * pos;
                rc = lc + 1;
                if (lc > heap_fill)
                    done = 1'b1;
                else if (rc > heap_fill)
                begin
                    if (heap_keys[pos] > heap_keys[lc])
                        swap_keys(pos, lc);
                    done = 1'b1;
                end
                else
                begin
                    // ties between children go right
                    pick = (heap_keys[rc] > heap_keys[lc]) ? lc : rc;
                    if (heap_keys[pos] > heap_keys[pick])
                    begin
                        swap_keys(pos, pick);
                        pos = pick;
                    end
                    else
                        done = 1'b1;
                end
            end
        end
        r.mn  = (heap_fill > 0) ? heap_keys[1] : '0;
        r.cnt = heap_fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic key_t rand_key();
        case ($urandom_range(0, 9))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2, 3, 4: return $signed($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic k, input key_t v, input logic typed,
                             input heap_result_t typed_res);
        heap_result_t r;
        int           gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        key      <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = apply_word(k, v);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
    endtask

    task automatic send_random(input int inserts_of_16);
        logic k;
        k = ($urandom_range(0, 15) < inserts_of_16) ? KIND_INSERT : KIND_REMOVE;
        send_word(k, rand_key(), 1'b0, '0);
    endtask

    // receiver side: random stall bursts plus the long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected word: removed_key %0d min_key %0d entry_count %0d status %0d",
                       removed_key, min_key, entry_count, status);
                mismatch_count++;
            end
            else
            begin
                heap_result_t e;
                e = pending_results.pop_front();
                if (removed_key !== e.rm)
                begin
                    $error("removed_key: expected %0d, got %0d", e.rm, removed_key);
                    mismatch_count++;
                end
                if (min_key !== e.mn)
                begin
                    $error("min_key: expected %0d, got %0d", e.mn, min_key);
                    mismatch_count++;
                end
                if (entry_count !== e.cnt)
                begin
                    $error("entry_count: expected %0d, got %0d", e.cnt, entry_count);
                    mismatch_count++;
                end
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_word(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);

        // small heap, empty removes and duplicate keys
        repeat (8) send_random(8);

        // fill to capacity, with the receiver holding off at the start, then work the full heap
        hold_requests++;
        while (heap_fill < CAP)
            send_random(16);
        repeat (12) send_random(8);

        // wait out every pending word before draining
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        // deep walks down from a nearly full heap
        repeat (12) send_random(2);

        calm = 1'b1;
        repeat (12) send_random(8);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
